FILE: hw/rtl/ist_pkg.sv
// Shared types and constants of the interval statistics table.
// Used by the top, the controller and the datapath; depends on nothing.
package ist_pkg;

    localparam logic       KIND_START  = 1'b0;
    localparam logic       KIND_STOP   = 1'b1;
    localparam logic [63:0] ALL_ONES64 = 64'hffff_ffff_ffff_ffff;
    localparam logic [31:0] FULL_COUNT = 32'hffff_ffff;

    typedef struct packed {
        logic        kind;
        logic [9:0]  slot;
        logic [63:0] timestamp;
    } t_in;

    typedef struct packed {
        logic [63:0] interval;
        logic [63:0] shortest;
        logic [63:0] longest;
        logic [63:0] sum;
        logic [31:0] tally;
        logic [63:0] mean;
        logic        saturated;
    } t_out;

    // One row of the slot memory.
    typedef struct packed {
        logic [63:0] start_stamp;
        logic [63:0] min_interval;
        logic [63:0] max_interval;
        logic [63:0] interval_total;
        logic [31:0] event_count;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        start_stamp:    64'd0,
        min_interval:   ALL_ONES64,
        max_interval:   64'd0,
        interval_total: 64'd0,
        event_count:    32'd0
    };

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_UPDATE,
        ST_DIVIDE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic rd;
        logic stamp_wr;
        logic diff;
        logic upd;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic is_stop;
        logic div_done;
    } t_sts;

endpackage

FILE: hw/rtl/interval_statistics_table.sv
// Interval statistics table: per-slot start/stop timing with min, max, total,
// count and mean. After reset the block holds busy high while it sweeps the slot
// memory to its reset values, one row a cycle. A start word keeps busy high through
// ST_READ and ST_DIFF after acceptance, a word for a slot beyond the table through
// ST_READ alone. A stop word keeps busy high through ST_READ, ST_DIFF, ST_UPDATE and
// ST_DIVIDE, and the next word can be taken only after that; most of that time is
// spent in the mean divider, which produces one quotient bit a cycle. Each stop for
// a slot in the table gives one result word on o_result, for the single cycle that
// strobe is high; the receiver must take it then, as there is no way to hold it off.
// Depends on ist_pkg, ist_ctrl and ist_dpath.
module interval_statistics_table #(
    parameter int SLOTS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ist_pkg::t_in  i_item,
    output logic          strobe,
    output ist_pkg::t_out o_result
);

    ist_pkg::t_cmd cmd;
    ist_pkg::t_sts sts;

    ist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    ist_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (strobe),
        .o_result (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |=> !strobe)
        else $error("two result words in consecutive cycles");

    a_tally_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> (o_result.tally != 32'd0))
        else $error("result word with zero tally");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> (o_result.shortest <= o_result.longest))
        else $error("shortest interval exceeds longest");

endmodule

FILE: hw/rtl/ist_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used by the datapath of the interval statistics table.
module ist_ram #(
    parameter int WIDTH = 288,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ist_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Stands alone; used by the datapath of the interval statistics table.
module ist_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    localparam logic [5:0] LAST_STEP = 6'd63;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_dvs;

    logic [32:0] shifted;
    logic [33:0] trial;
    logic        take;

    // The remainder stays below the divisor, so the shifted value fits in 33 bits.
    always_comb begin
        shifted = {r_rem, r_quo[63]};
        trial   = {1'b0, shifted} - {2'b00, r_dvs};
        take    = ~trial[33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? trial[31:0] : shifted[31:0];
            r_quo <= {r_quo[62:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: hw/rtl/ist_ctrl.sv
// Controller state machine of the interval statistics table.
// Depends on ist_pkg for the state, command and status types.
module ist_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ist_pkg::t_sts i_sts,
    output logic          o_busy,
    output ist_pkg::t_cmd o_cmd
);

    ist_pkg::t_state r_state;
    ist_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ist_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ist_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ist_pkg::ST_IDLE;
                end
            end
            ist_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ist_pkg::ST_READ;
                end
            end
            ist_pkg::ST_READ: begin
                // A slot beyond the table is dropped without a memory access.
                if (i_sts.in_range) begin
                    o_cmd.rd = 1'b1;
                    n_state  = ist_pkg::ST_DIFF;
                end else begin
                    n_state = ist_pkg::ST_IDLE;
                end
            end
            ist_pkg::ST_DIFF: begin
                if (i_sts.is_stop) begin
                    o_cmd.diff = 1'b1;
                    n_state    = ist_pkg::ST_UPDATE;
                end else begin
                    o_cmd.stamp_wr = 1'b1;
                    n_state        = ist_pkg::ST_IDLE;
                end
            end
            ist_pkg::ST_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = ist_pkg::ST_DIVIDE;
            end
            ist_pkg::ST_DIVIDE: begin
                if (i_sts.div_done) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ist_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ist_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ist_dpath.sv
// Datapath of the interval statistics table: slot memory, interval arithmetic,
// mean divider and result register. Depends on ist_pkg, ist_ram and ist_div.
module ist_dpath #(
    parameter int SLOTS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ist_pkg::t_in  i_item,
    input  ist_pkg::t_cmd i_cmd,
    output ist_pkg::t_sts o_sts,
    output logic          o_strobe,
    output ist_pkg::t_out o_result
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = $bits(ist_pkg::t_entry);

    ist_pkg::t_in    r_in;
    logic [AW-1:0]   r_clr_addr;
    ist_pkg::t_entry r_ent;
    logic [63:0]     r_diff;
    ist_pkg::t_out   r_res;
    logic            r_strobe;

    ist_pkg::t_entry n_ent;
    ist_pkg::t_entry rd_ent;
    ist_pkg::t_entry stamp_ent;
    logic            full;
    logic [AW-1:0]   slot_addr;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic [EW-1:0]   ram_rdata;

    logic            div_done;
    logic [63:0]     div_quo;

    assign slot_addr = AW'(r_in.slot);
    assign rd_ent    = ist_pkg::t_entry'(ram_rdata);

    always_comb begin
        full  = (r_ent.event_count == ist_pkg::FULL_COUNT);
        n_ent = r_ent;
        n_ent.start_stamp = '0;
        if (!full) begin
            if (r_diff < r_ent.min_interval) begin
                n_ent.min_interval = r_diff;
            end
            if (r_diff > r_ent.max_interval) begin
                n_ent.max_interval = r_diff;
            end
            n_ent.interval_total = r_ent.interval_total + r_diff;
            n_ent.event_count    = r_ent.event_count + 32'd1;
        end
        stamp_ent             = rd_ent;
        stamp_ent.start_stamp = r_in.timestamp;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_addr;
        ram_wdata = EW'(n_ent);
        if (i_cmd.clr_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = EW'(ist_pkg::ENTRY_RESET);
        end else if (i_cmd.stamp_wr) begin
            // A stored zero means the slot is not running, so only then is a start taken.
            ram_we    = (rd_ent.start_stamp == 64'd0);
            ram_wdata = EW'(stamp_ent);
        end else if (i_cmd.upd) begin
            ram_we = 1'b1;
        end
    end

    ist_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (slot_addr),
        .o_rdata (ram_rdata)
    );

    ist_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.upd),
        .i_dividend (n_ent.interval_total),
        .i_divisor  (n_ent.event_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.diff) begin
            r_ent  <= rd_ent;
            r_diff <= r_in.timestamp - rd_ent.start_stamp;
        end
        if (i_cmd.upd) begin
            r_res.interval  <= r_diff;
            r_res.shortest  <= n_ent.min_interval;
            r_res.longest   <= n_ent.max_interval;
            r_res.sum       <= n_ent.interval_total;
            r_res.tally     <= n_ent.event_count;
            r_res.saturated <= full;
        end
        if (i_cmd.emit) begin
            r_res.mean <= (r_res.tally == 32'd0) ? 64'd0 : div_quo;
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.clr_last = (r_clr_addr == AW'(SLOTS - 1));
        o_sts.in_range = (32'(r_in.slot) < 32'(SLOTS));
        o_sts.is_stop  = (r_in.kind == ist_pkg::KIND_STOP);
        o_sts.div_done = div_done;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

FILE: test/tb_interval_statistics_table.sv
// Self-checking testbench for interval_statistics_table: drives start and stop words,
// predicts every result word from its own copy of the slot table and checks each field.
// Depends on ist_pkg and the interval_statistics_table RTL.
module tb_interval_statistics_table;

    localparam int NUM_SLOTS     = 1024;
    localparam int WATCHDOG_MAX  = 10000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int REPORT_LIMIT  = 10;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    ist_pkg::t_in   i_item;
    logic           strobe;
    ist_pkg::t_out  o_result;

    // Predicted slot table.
    logic [63:0] slot_start [NUM_SLOTS];
    logic [63:0] slot_min   [NUM_SLOTS];
    logic [63:0] slot_max   [NUM_SLOTS];
    logic [63:0] slot_total [NUM_SLOTS];
    logic [31:0] slot_count [NUM_SLOTS];

    ist_pkg::t_out pending_results [$];
    int   mismatches;
    int   effective_words;
    int   sender_idle_pct;
    int   idle_cycles;

    interval_statistics_table #(
        .SLOTS(NUM_SLOTS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .strobe   (strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_table();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_start[i] = 64'd0;
            slot_min[i]   = ist_pkg::ALL_ONES64;
            slot_max[i]   = 64'd0;
            slot_total[i] = 64'd0;
            slot_count[i] = 32'd0;
        end
    endtask

    // Updates the predicted table for one accepted word and queues the result it causes.
    task automatic apply_event(input ist_pkg::t_in w);
        logic [63:0]   span;
        logic          full;
        ist_pkg::t_out r;
        if (w.slot >= NUM_SLOTS) begin
            return;
        end
        if (w.kind == ist_pkg::KIND_START) begin
            if (slot_start[w.slot] == 64'd0) begin
                slot_start[w.slot] = w.timestamp;
                effective_words++;
            end
            return;
        end
        effective_words++;
        span = w.timestamp - slot_start[w.slot];
        full = (slot_count[w.slot] == ist_pkg::FULL_COUNT);
        if (!full) begin
            if (span < slot_min[w.slot]) slot_min[w.slot] = span;
            if (span > slot_max[w.slot]) slot_max[w.slot] = span;
            slot_total[w.slot] = slot_total[w.slot] + span;
            slot_count[w.slot] = slot_count[w.slot] + 32'd1;
        end
        slot_start[w.slot] = 64'd0;
        r.interval  = span;
        r.shortest  = slot_min[w.slot];
        r.longest   = slot_max[w.slot];
        r.sum       = slot_total[w.slot];
        r.tally     = slot_count[w.slot];
        r.mean      = (slot_count[w.slot] != 32'd0) ?
                      slot_total[w.slot] / {32'd0, slot_count[w.slot]} : 64'd0;
        r.saturated = full;
        pending_results.push_back(r);
    endtask

    // Entered and left at a falling edge; start stays high when words follow back to back.
    task automatic send_word(input ist_pkg::t_in w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        apply_event(w);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_stamp();
        case ($urandom_range(3))
            0: pick_stamp = 64'($urandom_range(1000));
            1: pick_stamp = {$urandom, $urandom};
            2: pick_stamp = ist_pkg::ALL_ONES64 - 64'($urandom_range(1000));
            default: pick_stamp = 64'd1 << $urandom_range(63);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch in %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge i_clk) begin
        ist_pkg::t_out want;
        if (i_rst_n && strobe) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result word interval", 64'd0, o_result.interval);
            end else begin
                want = pending_results.pop_front();
                if (o_result.interval !== want.interval)
                    note_mismatch("interval", want.interval, o_result.interval);
                if (o_result.shortest !== want.shortest)
                    note_mismatch("shortest", want.shortest, o_result.shortest);
                if (o_result.longest !== want.longest)
                    note_mismatch("longest", want.longest, o_result.longest);
                if (o_result.sum !== want.sum)
                    note_mismatch("sum", want.sum, o_result.sum);
                if (o_result.tally !== want.tally)
                    note_mismatch("tally", 64'(want.tally), 64'(o_result.tally));
                if (o_result.mean !== want.mean)
                    note_mismatch("mean", want.mean, o_result.mean);
                if (o_result.saturated !== want.saturated)
                    note_mismatch("saturated", 64'(want.saturated), 64'(o_result.saturated));
            end
        end
    end

    // The reset sweep of the slot memory also counts here, so the limit covers it.
    always @(posedge i_clk) begin
        if ((start && !busy) || strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Start at zero, start while running and stop while idle.
    task automatic test_special_cases();
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: 10'd0,
                                 timestamp: 64'd0});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: 10'd0,
                                 timestamp: 64'd100});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: 10'd0,
                                 timestamp: 64'd5});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_STOP,  slot: 10'd0,
                                 timestamp: 64'd1100});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_STOP,  slot: 10'd0,
                                 timestamp: 64'd7});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_STOP,  slot: 10'd341,
                                 timestamp: 64'd0});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: 10'd682,
                                 timestamp: ist_pkg::ALL_ONES64});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: 10'd682,
                                 timestamp: 64'd0});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_STOP,  slot: 10'd682,
                                 timestamp: ist_pkg::ALL_ONES64});
    endtask

    // Extreme slots and timestamps; two of the stops wrap the running total.
    task automatic test_boundary_values();
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: 10'd1023,
                                 timestamp: ist_pkg::ALL_ONES64});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_STOP,  slot: 10'd1023,
                                 timestamp: 64'd4});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: 10'd1023,
                                 timestamp: 64'd1});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_STOP,  slot: 10'd1023,
                                 timestamp: 64'd0});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: 10'd512,
                                 timestamp: 64'h8000_0000_0000_0000});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_STOP,  slot: 10'd512,
                                 timestamp: ist_pkg::ALL_ONES64});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_STOP,  slot: 10'd512,
                                 timestamp: ist_pkg::ALL_ONES64});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: 10'd1023,
                                 timestamp: 64'h5555_5555_5555_5555});
        send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_STOP,  slot: 10'd1023,
                                 timestamp: 64'haaaa_aaaa_aaaa_aaaa});
    endtask

    // Mostly start/stop pairs on a few busy slots, with stray and random words between.
    // A full tally needs 2^32 - 1 stops on one slot and is left to the predictor alone.
    task automatic test_measurements(input int idle_pct, input int word_target);
        int          stop_at;
        logic [9:0]  s;
        logic [63:0] t0;
        sender_idle_pct = idle_pct;
        stop_at = effective_words + word_target;
        while (effective_words < stop_at) begin
            if ($urandom_range(99) < 15) begin
                send_word(ist_pkg::t_in'{kind: 1'($urandom_range(1)), slot: 10'($urandom),
                                         timestamp: {$urandom, $urandom}});
            end else begin
                s  = ($urandom_range(99) < 70) ? 10'($urandom_range(7)) : 10'($urandom);
                t0 = pick_stamp();
                send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: s, timestamp: t0});
                if ($urandom_range(99) < 20)
                    send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_START, slot: s,
                                             timestamp: pick_stamp()});
                send_word(ist_pkg::t_in'{kind: ist_pkg::KIND_STOP, slot: s,
                                         timestamp: t0 + pick_stamp()});
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_item          = '0;
        mismatches      = 0;
        effective_words = 0;
        sender_idle_pct = 0;
        idle_cycles     = 0;
        clear_table();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_boundary_values();
        test_measurements(31, 210);
        test_measurements(75, 210);
        test_measurements(0, 210);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ist_pkg.sv
hw/rtl/ist_ram.sv
hw/rtl/ist_div.sv
hw/rtl/ist_ctrl.sv
hw/rtl/ist_dpath.sv
hw/rtl/interval_statistics_table.sv
test/tb_interval_statistics_table.sv
